>>> src/pad_avg_pkg.sv
`default_nettype none

package pad_avg_pkg;

    // fixed field widths
    localparam int VALUE_BITS     = 16;
    localparam int ROWS_BITS      = 13;
    localparam int COLS_BITS      = 11;
    localparam int ROW_CNT_BITS   = 12;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 2;
    localparam int ROW_LIMIT      = 4096;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ORIG_ROWS   = 2'd0,
        REG_ORIG_COLS   = 2'd1,
        REG_PADDED_ROWS = 2'd2,
        REG_PADDED_COLS = 2'd3
    } cfg_reg_t;

endpackage

`default_nettype wire

>>> src/pad_avg_if.sv
`default_nettype none

// sample channel
interface pad_avg_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

// result channel
interface pad_avg_out_if;
    logic                             valid;
    logic                             ready;
    logic [pad_avg_pkg::VALUE_BITS-1:0] value;
    logic                             is_original;
    logic                             frame_end;

    modport source (output valid, output value, output is_original, output frame_end,
                    input ready);
    modport sink (input valid, input value, input is_original, input frame_end,
                  output ready);
endinterface

// configuration write channel
interface pad_avg_cfg_if;
    logic                                valid;
    logic                                ready;
    pad_avg_pkg::cfg_reg_t               index;
    logic [pad_avg_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> src/pad_image_neighbor_average.sv
`default_nettype none

// Pads an orig_rows x orig_cols image out to padded_rows x padded_cols, one cell per
// transfer in row-major order, one result per cell. Original cells pass through;
// padded cells get the truncated mean of the in-area cells among up-left, up, left and
// self. The block takes one cell per cycle while its output is taken: a cell enters the
// input stage together with its line-store read, is averaged on its way into the output
// register and sits there until taken, so each result passes the input stage and the
// output register in that order. After reset the line store is cleared one column per
// cycle, so no cell is taken until all MAX_COLS columns are cleared; configuration
// writes are taken at any time and should only be made while the block is idle.
module pad_image_neighbor_average #(
    parameter int MAX_COLS    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire           clk,
    input  wire           rst_n,
    pad_avg_in_if.sink    in_ch,
    pad_avg_out_if.source out_ch,
    pad_avg_cfg_if.sink   cfg
);

    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int COL_W  = $clog2(MAX_COLS + 1);
    localparam int SUM_W  = SAMPLE_BITS + 2;
    localparam int VB     = pad_avg_pkg::VALUE_BITS;

    // configuration registers
    logic [pad_avg_pkg::ROWS_BITS-1:0] orig_rows_reg;
    logic [pad_avg_pkg::COLS_BITS-1:0] orig_cols_reg;
    logic [pad_avg_pkg::ROWS_BITS-1:0] padded_rows_reg;
    logic [pad_avg_pkg::COLS_BITS-1:0] padded_cols_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orig_rows_reg   <= pad_avg_pkg::ROWS_BITS'(1);
            orig_cols_reg   <= pad_avg_pkg::COLS_BITS'(1);
            padded_rows_reg <= pad_avg_pkg::ROWS_BITS'(1);
            padded_cols_reg <= pad_avg_pkg::COLS_BITS'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                pad_avg_pkg::REG_ORIG_ROWS:   orig_rows_reg   <= cfg.data;
                pad_avg_pkg::REG_ORIG_COLS:   orig_cols_reg   <= cfg.data[pad_avg_pkg::COLS_BITS-1:0];
                pad_avg_pkg::REG_PADDED_ROWS: padded_rows_reg <= cfg.data;
                pad_avg_pkg::REG_PADDED_COLS: padded_cols_reg <= cfg.data[pad_avg_pkg::COLS_BITS-1:0];
                default: ;
            endcase
        end
    end

    // effective padded size
    logic [pad_avg_pkg::ROWS_BITS-1:0] rows_eff;
    logic [COL_W-1:0]                  cols_eff;
    logic [31:0]                       pad_cols_w;

    always_comb
    begin
        pad_cols_w = 32'(padded_cols_reg);
        if (padded_rows_reg == '0)
            rows_eff = pad_avg_pkg::ROWS_BITS'(1);
        else if (32'(padded_rows_reg) > 32'(pad_avg_pkg::ROW_LIMIT))
            rows_eff = pad_avg_pkg::ROWS_BITS'(pad_avg_pkg::ROW_LIMIT);
        else
            rows_eff = padded_rows_reg;
        if (pad_cols_w == 32'd0)
            cols_eff = COL_W'(1);
        else if (pad_cols_w > 32'(MAX_COLS))
            cols_eff = COL_W'(MAX_COLS);
        else
            cols_eff = COL_W'(pad_cols_w);
    end

    // handshake and stage control
    logic clearing_reg;
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_free;
    logic s1_move;
    logic in_xfer;

    assign out_free    = !out_valid_reg || out_ch.ready;
    assign s1_move     = s1_valid_reg && out_free;
    assign in_ch.ready = !clearing_reg && (!s1_valid_reg || s1_move);
    assign in_xfer     = in_ch.valid && in_ch.ready;

    // position of the incoming cell
    logic [pad_avg_pkg::ROW_CNT_BITS-1:0] row_reg, row_next;
    logic [COL_AW-1:0]                    col_reg, col_next;
    logic [pad_avg_pkg::ROW_CNT_BITS-1:0] cur_row;
    logic [COL_AW-1:0]                    cur_col;
    logic                                 wrap;
    logic                                 last_col;
    logic                                 last_row;
    logic                                 cur_orig;
    logic [SAMPLE_BITS-1:0]               cur_val;

    always_comb
    begin
        wrap     = (32'(row_reg) >= 32'(rows_eff)) || (32'(col_reg) >= 32'(cols_eff));
        cur_row  = wrap ? '0 : row_reg;
        cur_col  = wrap ? '0 : col_reg;
        last_col = (32'(cur_col) + 32'd1) >= 32'(cols_eff);
        last_row = (32'(cur_row) + 32'd1) >= 32'(rows_eff);
        cur_orig = (32'(cur_row) < 32'(orig_rows_reg)) && (32'(cur_col) < 32'(orig_cols_reg));
        cur_val  = cur_orig ? SAMPLE_BITS'(in_ch.sample) : '0;
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : cur_row + 1'b1;
        end
        else
        begin
            col_next = cur_col + 1'b1;
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (in_xfer)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // clearing pass over the line store
    logic [COL_AW-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_cnt_reg  <= '0;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (32'(clr_cnt_reg) == 32'(MAX_COLS - 1))
                clearing_reg <= 1'b0;
        end
    end

    // line store, read-first single port
    logic [SAMPLE_BITS-1:0] line_mem [MAX_COLS];
    logic [SAMPLE_BITS-1:0] upper_reg;
    logic                   mem_we;
    logic [COL_AW-1:0]      mem_addr;
    logic [SAMPLE_BITS-1:0] mem_wdata;

    assign mem_we    = clearing_reg || in_xfer;
    assign mem_addr  = clearing_reg ? clr_cnt_reg : cur_col;
    assign mem_wdata = clearing_reg ? '0 : cur_val;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[mem_addr] <= mem_wdata;
        if (in_xfer)
            upper_reg <= line_mem[mem_addr];
    end

    // input stage
    logic [SAMPLE_BITS-1:0] s1_cur_reg;
    logic                   s1_row0_reg;
    logic                   s1_col0_reg;
    logic                   s1_orig_reg;
    logic                   s1_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_xfer)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_cur_reg  <= cur_val;
            s1_row0_reg <= (cur_row == '0);
            s1_col0_reg <= (cur_col == '0);
            s1_orig_reg <= cur_orig;
            s1_end_reg  <= last_row && last_col;
        end
    end

    // neighbor history, advanced as each cell leaves the input stage
    logic [SAMPLE_BITS-1:0] left_reg;
    logic [SAMPLE_BITS-1:0] upper_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else if (s1_move)
        begin
            left_reg       <= s1_cur_reg;
            upper_left_reg <= upper_reg;
        end
    end

    // neighbor mean
    logic [SUM_W-1:0]    avg;
    logic [SUM_W+VB-1:0] avg_wide;

    always_comb
    begin
        if (s1_orig_reg || (s1_row0_reg && s1_col0_reg))
            avg = SUM_W'(s1_cur_reg);
        else if (s1_row0_reg)
            avg = (SUM_W'(left_reg) + SUM_W'(s1_cur_reg)) >> 1;
        else if (s1_col0_reg)
            avg = (SUM_W'(upper_reg) + SUM_W'(s1_cur_reg)) >> 1;
        else
            avg = (SUM_W'(upper_left_reg) + SUM_W'(upper_reg) + SUM_W'(left_reg)
                   + SUM_W'(s1_cur_reg)) >> 2;
        avg_wide = {{VB{1'b0}}, avg};
    end

    // output register
    logic [VB-1:0] value_reg;
    logic          is_original_reg;
    logic          frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            value_reg       <= avg_wide[VB-1:0];
            is_original_reg <= s1_orig_reg;
            frame_end_reg   <= s1_end_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.value       = value_reg;
    assign out_ch.is_original = is_original_reg;
    assign out_ch.frame_end   = frame_end_reg;

    // no cell is taken while the line store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clearing_reg |-> !in_ch.ready)
        else $error("cell taken during line store clear");

    // a cell held in the input stage behind a full output is not dropped
    assert property (@(posedge clk) disable iff (!rst_n)
                     (s1_valid_reg && !out_free) |=> s1_valid_reg)
        else $error("input stage lost a cell");

    // an original cell passes its sample through unchanged
    assert property (@(posedge clk) disable iff (!rst_n)
                     (s1_move && s1_orig_reg) |=> (out_ch.is_original
                      && out_ch.value == $past(avg_wide[VB-1:0])))
        else $error("original cell not passed through");

endmodule

`default_nettype wire
